### rtl/vector_difference_metrics_macros.svh
// Assertion macros shared by the vector difference metrics RTL.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef VECTOR_DIFFERENCE_METRICS_MACROS_SVH
`define VECTOR_DIFFERENCE_METRICS_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled during reset.
`define VDM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_difference_metrics assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define VDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector_difference_metrics assertion failed");

`else

`define VDM_ASSERT_IMPL(lbl, ante, cons)
`define VDM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/vdm_pkg.sv
// Types and fixed constants for the vector difference metrics block.
// Depends on nothing; used by vdm_cmpsub and vector_difference_metrics.
package vdm_pkg;

  // Width of the shared compare/subtract unit: the square root remainder
  // plus two incoming bits, which also covers the divider trial value.
  localparam int SUB_W = 34;

  // Width of the accumulated sum of squares.
  localparam int SUM_W = 64;

  // Root digits produced for a 64-bit radicand, one per step.
  localparam int SQRT_STEPS = 32;

  // Step counter width, enough for the longer of division and square root.
  localparam int CNT_W = 5;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIFF = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_REL  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

endpackage

### rtl/vdm_cmpsub.sv
// Shared compare and subtract unit used by the divider and the square root.
// Depends on vdm_pkg for its width.
module vdm_cmpsub (
  input  logic [vdm_pkg::SUB_W-1:0] minuend,
  input  logic [vdm_pkg::SUB_W-1:0] subtrahend,
  output logic                      ge,
  output logic [vdm_pkg::SUB_W-1:0] diff
);

  localparam int SW = vdm_pkg::SUB_W;

  logic [SW:0] wide_diff;

  // The borrow out of the extended subtraction tells whether minuend >= subtrahend.
  assign wide_diff = {1'b0, minuend} - {1'b0, subtrahend};
  assign ge        = ~wide_diff[SW];
  assign diff      = wide_diff[SW-1:0];

endmodule

### rtl/vector_difference_metrics.sv
// Vector difference metrics: L2 distance, largest absolute and relative error.
// Depends on vdm_pkg, vdm_cmpsub and vector_difference_metrics_macros.svh.
//
// Usage: element pairs arrive on the in_ channel (in_ref_value, in_test_value,
// signed fixed point with FRAC_BITS fraction bits, low WORD_WIDTH bits used),
// with in_last marking the final pair. Each transfer updates a saturating
// 64-bit sum of squared differences and the two running maxima. The item
// marked last produces one transfer on the out_ channel carrying the integer
// square root of the sum and both maxima; the state then clears for the next
// vector. Other items produce no result.
// Timing: in_ready is high only when the sequencer is idle. An item that needs
// the divider passes the difference, square, accumulate, divide and relative
// states before in_ready returns (one divider step per cycle on the shared
// subtract unit); a zero reference or a quotient known to saturate skips the
// divide state. A last item then adds 32 square root steps and the load of
// the output register, where the result sits, so the next vector's items
// are taken while it waits. If the previous result is still not taken when
// another is done, the sequencer holds in_ready low until the register frees.
// Reset (rst_n low, synchronous) clears the sums, maxima and out_valid.
`include "vector_difference_metrics_macros.svh"

module vector_difference_metrics #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_ref_value,
  input  logic signed [31:0] in_test_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_l2_distance,
  output logic [31:0]        out_max_abs_difference,
  output logic [31:0]        out_max_rel_difference
);

  localparam int WW     = WORD_WIDTH;
  localparam int AW     = WORD_WIDTH + 1;
  localparam int NUM_W  = WORD_WIDTH + 1 + FRAC_BITS;
  localparam int PROD_W = 2 * AW;
  localparam int SW     = vdm_pkg::SUB_W;
  localparam int SUM_W  = vdm_pkg::SUM_W;
  localparam int CW     = vdm_pkg::CNT_W;
  localparam logic [WW-1:0] WMASK = {WW{1'b1}};

  vdm_pkg::state_t state_r, state_nxt;

  logic signed [WW-1:0] a_r, b_r;
  logic                 last_r;
  logic [AW-1:0]        absd_r;
  logic [WW-1:0]        absa_r;
  logic [SUM_W-1:0]     sq_r;
  logic [SUM_W-1:0]     sum_r;
  logic [WW-1:0]        max_abs_r;
  logic [WW-1:0]        max_rel_r;
  logic                 rel_en_r;
  logic                 rel_sat_r;
  logic [SW-1:0]        rem_r;
  logic [SUM_W-1:0]     work_r;
  logic [31:0]          root_r;
  logic [CW-1:0]        cnt_r;
  logic                 out_valid_r;
  logic [WW-1:0]        l2_r, oabs_r, orel_r;

  // Difference stage.
  logic signed [AW-1:0] diff_s;
  logic [AW-1:0]        absd_c;
  logic [WW-1:0]        absa_c;

  // Square and divider setup stage.
  logic [PROD_W-1:0]    prod;
  logic                 sq_sat;
  logic [SUM_W-1:0]     sq_c;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     num_hi;
  logic                 div_sat;
  logic [WW-1:0]        abs_word;

  // Accumulate and relative update.
  logic [SUM_W:0]       sum_add;
  logic [WW-1:0]        rel_word;
  logic [WW-1:0]        root_word;

  // Shared unit.
  logic [SW-1:0]        sub_a, sub_b, sub_diff;
  logic                 sub_ge;
  logic                 load_out;

  assign diff_s = {a_r[WW-1], a_r} - {b_r[WW-1], b_r};
  assign absd_c = diff_s[AW-1] ? AW'(-diff_s) : AW'(diff_s);
  assign absa_c = a_r[WW-1] ? WW'(-a_r) : WW'(a_r);

  assign prod     = absd_r * absd_r;
  assign sq_sat   = 64'(absd_r) > 64'h0000_0000_FFFF_FFFF;
  assign sq_c     = sq_sat ? {SUM_W{1'b1}} : SUM_W'(prod);
  assign num      = NUM_W'(absd_r) << FRAC_BITS;
  assign num_hi   = num >> WW;
  // The quotient saturates exactly when the part above the low word already
  // reaches the divisor, so the divider only needs WORD_WIDTH steps.
  assign div_sat  = num_hi >= NUM_W'(absa_r);
  assign abs_word = absd_r[WW] ? WMASK : absd_r[WW-1:0];

  assign sum_add   = {1'b0, sum_r} + {1'b0, sq_r};
  assign rel_word  = rel_sat_r ? WMASK : work_r[WW-1:0];
  assign root_word = (root_r > 32'(WMASK)) ? WMASK : root_r[WW-1:0];

  always_comb begin
    if (state_r == vdm_pkg::S_DIV) begin
      sub_a = SW'({rem_r[WW-1:0], work_r[WW-1]});
      sub_b = SW'(absa_r);
    end else begin
      sub_a = {rem_r[31:0], work_r[SUM_W-1:SUM_W-2]};
      sub_b = {root_r, 2'b01};
    end
  end

  vdm_cmpsub u_cmpsub (
    .minuend    (sub_a),
    .subtrahend (sub_b),
    .ge         (sub_ge),
    .diff       (sub_diff)
  );

  assign load_out = (state_r == vdm_pkg::S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vdm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = vdm_pkg::S_DIFF;
      end
      vdm_pkg::S_DIFF: state_nxt = vdm_pkg::S_MUL;
      vdm_pkg::S_MUL:  state_nxt = vdm_pkg::S_ACC;
      vdm_pkg::S_ACC: begin
        if (rel_en_r && !rel_sat_r) state_nxt = vdm_pkg::S_DIV;
        else                        state_nxt = vdm_pkg::S_REL;
      end
      vdm_pkg::S_DIV: begin
        if (cnt_r == '0) state_nxt = vdm_pkg::S_REL;
      end
      vdm_pkg::S_REL: begin
        if (last_r) state_nxt = vdm_pkg::S_SQRT;
        else        state_nxt = vdm_pkg::S_IDLE;
      end
      vdm_pkg::S_SQRT: begin
        if (cnt_r == '0) state_nxt = vdm_pkg::S_DONE;
      end
      vdm_pkg::S_DONE: begin
        if (load_out) state_nxt = vdm_pkg::S_IDLE;
      end
      default: state_nxt = vdm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdm_pkg::S_IDLE;
      sum_r       <= '0;
      max_abs_r   <= '0;
      max_rel_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        max_abs_r   <= '0;
        max_rel_r   <= '0;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        if (state_r == vdm_pkg::S_MUL && abs_word > max_abs_r) max_abs_r <= abs_word;
        if (state_r == vdm_pkg::S_ACC) sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        if (state_r == vdm_pkg::S_REL && rel_en_r && rel_word > max_rel_r) max_rel_r <= rel_word;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      vdm_pkg::S_IDLE: begin
        a_r    <= in_ref_value[WW-1:0];
        b_r    <= in_test_value[WW-1:0];
        last_r <= in_last;
      end
      vdm_pkg::S_DIFF: begin
        absd_r <= absd_c;
        absa_r <= absa_c;
      end
      vdm_pkg::S_MUL: begin
        sq_r      <= sq_c;
        rel_en_r  <= absa_r != '0;
        rel_sat_r <= div_sat;
        rem_r     <= SW'(num_hi);
        work_r    <= SUM_W'(num[WW-1:0]);
        cnt_r     <= CW'(WW - 1);
      end
      vdm_pkg::S_DIV: begin
        // Restoring division: shift in one numerator bit, keep the quotient
        // bit in the vacated low position of the same register.
        if (sub_ge) rem_r <= SW'(sub_diff[WW-1:0]);
        else        rem_r <= SW'(sub_a[WW-1:0]);
        work_r <= SUM_W'({work_r[WW-2:0], sub_ge});
        cnt_r  <= cnt_r - 1'b1;
      end
      vdm_pkg::S_REL: begin
        rem_r  <= '0;
        root_r <= '0;
        work_r <= sum_r;
        cnt_r  <= CW'(vdm_pkg::SQRT_STEPS - 1);
      end
      vdm_pkg::S_SQRT: begin
        // One root digit per step from the top pair of radicand bits.
        if (sub_ge) begin
          rem_r  <= sub_diff;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= sub_a;
          root_r <= {root_r[30:0], 1'b0};
        end
        work_r <= {work_r[SUM_W-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
      end
      vdm_pkg::S_DONE: begin
        if (load_out) begin
          l2_r   <= root_word;
          oabs_r <= max_abs_r;
          orel_r <= max_rel_r;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign in_ready               = state_r == vdm_pkg::S_IDLE;
  assign out_valid              = out_valid_r;
  assign out_l2_distance        = 32'(l2_r);
  assign out_max_abs_difference = 32'(oabs_r);
  assign out_max_rel_difference = 32'(orel_r);

  `VDM_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == vdm_pkg::S_DIFF)
  `VDM_ASSERT_NEXT(a_div_ends, state_r == vdm_pkg::S_DIV && cnt_r == '0, state_r == vdm_pkg::S_REL)
  `VDM_ASSERT_NEXT(a_sum_grows, state_r == vdm_pkg::S_ACC, sum_r >= $past(sum_r))
  `VDM_ASSERT_NEXT(a_rel_grows, state_r == vdm_pkg::S_REL, max_rel_r >= $past(max_rel_r))
  `VDM_ASSERT_IMPL(a_out_from_done, $rose(out_valid_r), $past(state_r == vdm_pkg::S_DONE))

endmodule
